// File: rtl/x25ffp_pkg.sv
// Shared types and codes for the X.25 facility field parser.
package x25ffp_pkg;

    localparam int CODE_LEN_SHIFT = 6;

    typedef enum logic [2:0] {
        ROLE_FIELD_LEN  = 3'd0,
        ROLE_CODE       = 3'd1,
        ROLE_LEN_OCTET  = 3'd2,
        ROLE_PARAM      = 3'd3,
        ROLE_AFTER      = 3'd4,
        ROLE_IGNORED    = 3'd5
    } byte_role_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_BUFFER_SHORT = 2'd1,
        ERR_NO_LEN_OCTET = 2'd2,
        ERR_PARAM_LONG   = 2'd3
    } error_kind_t;

    typedef struct packed {
        byte_role_t  byte_role;
        logic [7:0]  fac_code;
        logic [7:0]  param_index;
        logic [7:0]  param_length;
        logic        facility_done;
        logic        field_done;
        logic [8:0]  consumed;
        logic        error;
        error_kind_t error_kind;
    } result_t;

endpackage

// File: rtl/x25_facility_field_parser_unit.sv
// X.25 facility field parser: tags each byte of a facility field and flags completion/errors.
// Each accepted byte's result is registered in the output stage (skid register while stalled).
// Throughput: one byte per cycle while the skid register is empty (in_ready high).
// A two-entry output stage (result plus skid register) absorbs one byte during a stall.
// Reset: async active-low rst_n puts the parser at the facility length byte, no results pending.
module x25_facility_field_parser_unit
    import x25ffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_role,
    output logic [7:0]  fac_code,
    output logic [7:0]  param_index,
    output logic [7:0]  param_length,
    output logic        facility_done,
    output logic        field_done,
    output logic [8:0]  consumed,
    output logic        error,
    output logic [1:0]  error_kind
);

    typedef enum logic [2:0] {
        PH_FIELD_LEN = 3'd0,
        PH_CODE      = 3'd1,
        PH_LEN_OCTET = 3'd2,
        PH_PARAM     = 3'd3,
        PH_AFTER     = 3'd4,
        PH_ERROR     = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] field_left_reg, field_left_next;
    logic [7:0] param_left_reg, param_left_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] plen_reg, plen_next;
    logic [7:0] ppos_reg, ppos_next;
    logic [7:0] flen_reg, flen_next;

    result_t    res;
    result_t    out_data_reg;
    result_t    skid_data_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;

    logic       in_fire;
    logic       out_load;
    logic [7:0] field_left_dec;
    logic [7:0] param_left_dec;
    logic [1:0] top_bits;
    logic [7:0] short_len;
    logic [8:0] consumed_val;

    assign in_ready       = !skid_valid_reg;
    assign in_fire        = in_valid && in_ready;
    assign out_load       = !out_valid_reg || out_ready;
    assign field_left_dec = field_left_reg - 8'd1;
    assign param_left_dec = param_left_reg - 8'd1;
    assign top_bits       = data_byte[CODE_LEN_SHIFT+1:CODE_LEN_SHIFT];
    assign short_len      = {6'd0, top_bits} + 8'd1;
    assign consumed_val   = {1'b0, flen_reg} + 9'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        field_left_next = field_left_reg;
        param_left_next = param_left_reg;
        code_next       = code_reg;
        plen_next       = plen_reg;
        ppos_next       = ppos_reg;
        flen_next       = flen_reg;

        res               = '0;
        res.byte_role     = ROLE_IGNORED;
        res.error_kind    = ERR_NONE;

        unique case (phase_reg)
            PH_FIELD_LEN:
            begin
                res.byte_role   = ROLE_FIELD_LEN;
                flen_next       = data_byte;
                field_left_next = data_byte;
                if (data_byte == 8'd0)
                begin
                    res.field_done = 1'b1;
                    res.consumed   = 9'd1;
                    phase_next     = PH_AFTER;
                end
                else
                begin
                    phase_next = PH_CODE;
                end
            end
            PH_CODE:
            begin
                res.byte_role   = ROLE_CODE;
                res.fac_code    = data_byte;
                code_next       = data_byte;
                field_left_next = field_left_dec;
                if (top_bits != 2'b11)
                begin
                    plen_next        = short_len;
                    res.param_length = short_len;
                    if (field_left_dec < short_len)
                    begin
                        res.error      = 1'b1;
                        res.error_kind = ERR_PARAM_LONG;
                        phase_next     = PH_ERROR;
                    end
                    else
                    begin
                        param_left_next = short_len;
                        ppos_next       = 8'd0;
                        phase_next      = PH_PARAM;
                    end
                end
                else
                begin
                    plen_next = 8'd0;
                    if (field_left_dec != 8'd0)
                    begin
                        phase_next = PH_LEN_OCTET;
                    end
                    else
                    begin
                        res.error      = 1'b1;
                        res.error_kind = ERR_NO_LEN_OCTET;
                        phase_next     = PH_ERROR;
                    end
                end
            end
            PH_LEN_OCTET:
            begin
                res.byte_role    = ROLE_LEN_OCTET;
                res.fac_code     = code_reg;
                res.param_length = data_byte;
                field_left_next  = field_left_dec;
                plen_next        = data_byte;
                if (field_left_dec < data_byte)
                begin
                    res.error      = 1'b1;
                    res.error_kind = ERR_PARAM_LONG;
                    phase_next     = PH_ERROR;
                end
                else if (data_byte == 8'd0)
                begin
                    res.facility_done = 1'b1;
                    if (field_left_dec == 8'd0)
                    begin
                        res.field_done = 1'b1;
                        res.consumed   = consumed_val;
                        phase_next     = PH_AFTER;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
                else
                begin
                    param_left_next = data_byte;
                    ppos_next       = 8'd0;
                    phase_next      = PH_PARAM;
                end
            end
            PH_PARAM:
            begin
                res.byte_role    = ROLE_PARAM;
                res.fac_code     = code_reg;
                res.param_length = plen_reg;
                res.param_index  = ppos_reg;
                ppos_next        = ppos_reg + 8'd1;
                param_left_next  = param_left_dec;
                field_left_next  = field_left_dec;
                if (param_left_dec == 8'd0)
                begin
                    res.facility_done = 1'b1;
                    if (field_left_dec == 8'd0)
                    begin
                        res.field_done = 1'b1;
                        res.consumed   = consumed_val;
                        phase_next     = PH_AFTER;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
            end
            PH_AFTER:
            begin
                res.byte_role = ROLE_AFTER;
            end
            default:
            begin
                res.byte_role = ROLE_IGNORED;
            end
        endcase

        if (last_of_buffer)
        begin
            if (!res.error && phase_next != PH_AFTER && phase_next != PH_ERROR)
            begin
                res.error      = 1'b1;
                res.error_kind = ERR_BUFFER_SHORT;
            end
            phase_next      = PH_FIELD_LEN;
            field_left_next = 8'd0;
            param_left_next = 8'd0;
            code_next       = 8'd0;
            plen_next       = 8'd0;
            ppos_next       = 8'd0;
            flen_next       = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIELD_LEN;
            field_left_reg <= 8'd0;
            param_left_reg <= 8'd0;
            code_reg       <= 8'd0;
            plen_reg       <= 8'd0;
            ppos_reg       <= 8'd0;
            flen_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg      <= phase_next;
                field_left_reg <= field_left_next;
                param_left_reg <= param_left_next;
                code_reg       <= code_next;
                plen_reg       <= plen_next;
                ppos_reg       <= ppos_next;
                flen_reg       <= flen_next;
            end
            if (out_load)
            begin
                out_valid_reg  <= skid_valid_reg || in_fire;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (in_fire)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_role     = out_data_reg.byte_role;
    assign fac_code      = out_data_reg.fac_code;
    assign param_index   = out_data_reg.param_index;
    assign param_length  = out_data_reg.param_length;
    assign facility_done = out_data_reg.facility_done;
    assign field_done    = out_data_reg.field_done;
    assign consumed      = out_data_reg.consumed;
    assign error         = out_data_reg.error;
    assign error_kind    = out_data_reg.error_kind;

endmodule

// File: verif/tb_x25_facility_field_parser_unit.sv
// Self-checking testbench for the X.25 facility field parser unit.
module tb_x25_facility_field_parser_unit
    import x25ffp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED    = 26;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_AFTER    = 600;
    localparam int HOLD_CYCLES   = 150;

    typedef enum logic [2:0] {
        PH_FIELD_LEN,
        PH_CODE,
        PH_LEN_OCTET,
        PH_PARAM,
        PH_AFTER,
        PH_ERROR
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    tag;
    } stim_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte      = 8'd0;
    logic        last_of_buffer = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [2:0]  byte_role;
    logic [7:0]  fac_code;
    logic [7:0]  param_index;
    logic [7:0]  param_length;
    logic        facility_done;
    logic        field_done;
    logic [8:0]  consumed;
    logic        error;
    logic [1:0]  error_kind;

    // parser state mirror
    parse_phase_t ph;
    logic [7:0]   field_left;
    logic [7:0]   param_left;
    logic [7:0]   cur_code;
    logic [7:0]   cur_len;
    logic [7:0]   cur_pos;
    logic [7:0]   field_len;

    stim_t   stim_q[$];
    stim_t   directed_tab[N_DIRECTED];
    result_t pending_tags[$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      cycle_count  = 0;

    x25_facility_field_parser_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_of_buffer (last_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_role      (byte_role),
        .fac_code       (fac_code),
        .param_index    (param_index),
        .param_length   (param_length),
        .facility_done  (facility_done),
        .field_done     (field_done),
        .consumed       (consumed),
        .error          (error),
        .error_kind     (error_kind)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t mk_result(byte_role_t role, logic [7:0] code, logic [7:0] idx,
                                          logic [7:0] len, logic fac, logic fld,
                                          logic [8:0] cons, logic err, error_kind_t kind);
        result_t r;
        r = '{role, code, idx, len, fac, fld, cons, err, kind};
        return r;
    endfunction

    task automatic clear_parser();
        ph         = PH_FIELD_LEN;
        field_left = 8'd0;
        param_left = 8'd0;
        cur_code   = 8'd0;
        cur_len    = 8'd0;
        cur_pos    = 8'd0;
        field_len  = 8'd0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last, output result_t r);
        logic [1:0] top;
        r = '0;
        r.byte_role  = ROLE_IGNORED;
        r.error_kind = ERR_NONE;
        case (ph)
            PH_FIELD_LEN:
            begin
                r.byte_role = ROLE_FIELD_LEN;
                field_len   = b;
                field_left  = b;
                if (b == 8'd0)
                begin
                    r.field_done = 1'b1;
                    r.consumed   = 9'd1;
                    ph           = PH_AFTER;
                end
                else
                begin
                    ph = PH_CODE;
                end
            end
            PH_CODE:
            begin
                top         = 2'(b >> CODE_LEN_SHIFT);
                r.byte_role = ROLE_CODE;
                cur_code    = b;
                r.fac_code  = b;
                field_left  = field_left - 8'd1;
                if (top != 2'b11)
                begin
                    cur_len        = 8'(top) + 8'd1;
                    r.param_length = cur_len;
                    if (field_left < cur_len)
                    begin
                        r.error      = 1'b1;
                        r.error_kind = ERR_PARAM_LONG;
                        ph           = PH_ERROR;
                    end
                    else
                    begin
                        param_left = cur_len;
                        cur_pos    = 8'd0;
                        ph         = PH_PARAM;
                    end
                end
                else
                begin
                    cur_len = 8'd0;
                    if (field_left > 8'd0)
                    begin
                        ph = PH_LEN_OCTET;
                    end
                    else
                    begin
                        r.error      = 1'b1;
                        r.error_kind = ERR_NO_LEN_OCTET;
                        ph           = PH_ERROR;
                    end
                end
            end
            PH_LEN_OCTET:
            begin
                r.byte_role    = ROLE_LEN_OCTET;
                r.fac_code     = cur_code;
                field_left     = field_left - 8'd1;
                cur_len        = b;
                r.param_length = b;
                if (field_left < b)
                begin
                    r.error      = 1'b1;
                    r.error_kind = ERR_PARAM_LONG;
                    ph           = PH_ERROR;
                end
                else if (b == 8'd0)
                begin
                    r.facility_done = 1'b1;
                    if (field_left == 8'd0)
                    begin
                        r.field_done = 1'b1;
                        r.consumed   = 9'(field_len) + 9'd1;
                        ph           = PH_AFTER;
                    end
                    else
                    begin
                        ph = PH_CODE;
                    end
                end
                else
                begin
                    param_left = b;
                    cur_pos    = 8'd0;
                    ph         = PH_PARAM;
                end
            end
            PH_PARAM:
            begin
                r.byte_role    = ROLE_PARAM;
                r.fac_code     = cur_code;
                r.param_length = cur_len;
                r.param_index  = cur_pos;
                cur_pos        = cur_pos + 8'd1;
                param_left     = param_left - 8'd1;
                field_left     = field_left - 8'd1;
                if (param_left == 8'd0)
                begin
                    r.facility_done = 1'b1;
                    if (field_left == 8'd0)
                    begin
                        r.field_done = 1'b1;
                        r.consumed   = 9'(field_len) + 9'd1;
                        ph           = PH_AFTER;
                    end
                    else
                    begin
                        ph = PH_CODE;
                    end
                end
            end
            PH_AFTER:
            begin
                r.byte_role = ROLE_AFTER;
            end
            default:
            begin
                r.byte_role = ROLE_IGNORED;
            end
        endcase
        if (last)
        begin
            if (!r.error && ph != PH_AFTER && ph != PH_ERROR)
            begin
                r.error      = 1'b1;
                r.error_kind = ERR_BUFFER_SHORT;
            end
            clear_parser();
        end
    endtask

    // one buffer: mostly well-formed fields, some noise, corruption, truncation and trailing bytes
    task automatic add_random_buffer(inout int counted);
        logic [7:0] body[$];
        logic [7:0] seq[$];
        int         target;
        int         rem;
        int         top;
        int         oct;
        int         n;
        int         i;
        stim_t      s;
        n = $urandom_range(0, 99);
        if (n < 12)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                seq.push_back(8'($urandom));
            counted += n;
        end
        else
        begin
            target = ($urandom_range(0, 79) == 0) ? $urandom_range(200, 255)
                                                  : $urandom_range(0, 24);
            while (body.size() + 2 <= target)
            begin
                rem = target - body.size();
                top = $urandom_range(0, 3);
                if (top < 3 && top + 2 > rem)
                    top = 0;
                body.push_back({2'(top), 6'($urandom)});
                if (top < 3)
                begin
                    oct = top + 1;
                end
                else
                begin
                    oct = $urandom_range(0, (rem - 2 < 12) ? rem - 2 : 12);
                    body.push_back(8'(oct));
                end
                repeat (oct) body.push_back(8'($urandom));
            end
            seq.push_back(8'(body.size()));
            seq = {seq, body};
            counted += seq.size();
            if ($urandom_range(0, 9) == 0)
            begin
                i = $urandom_range(0, seq.size() - 1);
                seq[i] ^= 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, seq.size());
                while (seq.size() > n)
                    void'(seq.pop_back());
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
            end
        end
        for (i = 0; i < seq.size(); i++)
        begin
            s      = '0;
            s.data = seq[i];
            s.last = (i == seq.size() - 1);
            stim_q.push_back(s);
        end
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got = result_t'({byte_role, fac_code, param_index, param_length, facility_done,
                         field_done, consumed, error, error_kind});
        results_seen++;
        if (pending_tags.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result transaction, role %0d", $realtime, byte_role);
        end
        else
        begin
            want = pending_tags.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("%0t: result %0d exp/act role %0d/%0d code %h/%h idx %0d/%0d",
                           $realtime, results_seen, want.byte_role, got.byte_role,
                           want.fac_code, got.fac_code, want.param_index, got.param_index);
                    $display(" len %0d/%0d fac %b/%b fld %b/%b cons %0d/%0d err %b/%b kind %0d/%0d",
                             want.param_length, got.param_length, want.facility_done,
                             got.facility_done, want.field_done, got.field_done,
                             want.consumed, got.consumed, want.error, got.error,
                             want.error_kind, got.error_kind);
                end
            end
        end
    endtask

    // receiver: shifting stall patterns plus one long hold-off
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        int  tick;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            tick++;
            if (out_valid && out_ready)
                check_result();
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (tick % 3 == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        result_t pred;
        stim_t   s;
        int      counted;
        int      burst_left;
        int      gap;
        clear_parser();
        directed_tab = '{
            '{8'h00, 1'b1, 1'b1, mk_result(ROLE_FIELD_LEN, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1,
                                           9'd1, 1'b0, ERR_NONE)},
            '{8'h00, 1'b0, 1'b1, mk_result(ROLE_FIELD_LEN, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1,
                                           9'd1, 1'b0, ERR_NONE)},
            '{8'hAB, 1'b1, 1'b1, mk_result(ROLE_AFTER, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b0, ERR_NONE)},
            '{8'hFF, 1'b1, 1'b1, mk_result(ROLE_FIELD_LEN, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b1, ERR_BUFFER_SHORT)},
            '{8'h01, 1'b0, 1'b1, mk_result(ROLE_FIELD_LEN, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b0, ERR_NONE)},
            '{8'hC5, 1'b1, 1'b1, mk_result(ROLE_CODE, 8'hC5, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b1, ERR_NO_LEN_OCTET)},
            '{8'h02, 1'b0, 1'b1, mk_result(ROLE_FIELD_LEN, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b0, ERR_NONE)},
            '{8'h80, 1'b0, 1'b1, mk_result(ROLE_CODE, 8'h80, 8'd0, 8'd3, 1'b0, 1'b0,
                                           9'd0, 1'b1, ERR_PARAM_LONG)},
            '{8'h00, 1'b1, 1'b1, mk_result(ROLE_IGNORED, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b0, ERR_NONE)},
            '{8'h03, 1'b0, 1'b1, mk_result(ROLE_FIELD_LEN, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b0, ERR_NONE)},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h05, 1'b0, 1'b1, mk_result(ROLE_LEN_OCTET, 8'hFF, 8'd0, 8'd5, 1'b0, 1'b0,
                                           9'd0, 1'b1, ERR_PARAM_LONG)},
            '{8'h00, 1'b1, 1'b1, mk_result(ROLE_IGNORED, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0,
                                           9'd0, 1'b0, ERR_NONE)},
            // zero length octet closes the field
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'hC0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            // well-formed field with one-byte and three-byte parameters, a zero length octet, then a trailing byte
            '{8'h08, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h9C, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'hC2, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hEE, 1'b1, 1'b0, '0}
        };
        foreach (directed_tab[i])
            stim_q.push_back(directed_tab[i]);
        counted = 0;
        while (counted < RANDOM_ITEMS)
            add_random_buffer(counted);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        while (stim_q.size() != 0)
        begin
            s = stim_q.pop_front();
            in_valid       <= 1'b1;
            data_byte      <= s.data;
            last_of_buffer <= s.last;
            do
                @(posedge clk);
            while (!in_ready);
            parse_byte(s.data, s.last, pred);
            pending_tags.push_back(s.typed ? s.tag : pred);
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 120)
                                                        : $urandom_range(0, 8);
                gap = ($urandom_range(0, 19) == 0) ? 12 : $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
        in_valid <= 1'b0;

        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/x25ffp_pkg.sv
rtl/x25_facility_field_parser_unit.sv
verif/tb_x25_facility_field_parser_unit.sv
